FILE: design/beeq_pkg.sv
// ----------------------------------------------------------------------------
// beeq_pkg
// Shared types and constants for the button and encoder event qualifier.
// ----------------------------------------------------------------------------
package beeq_pkg;

   localparam int HOLD_COUNT_BITS = 8;
   localparam int THRESH_BITS     = 8;
   localparam int CMP_BITS        = (HOLD_COUNT_BITS > THRESH_BITS) ?
                                    HOLD_COUNT_BITS : THRESH_BITS;

   localparam logic [THRESH_BITS-1:0] LONG_PRESS_RESET = THRESH_BITS'(50);

   // old/new phase pair patterns
   localparam logic [3:0] PAT_LEFT_A  = 4'd1;
   localparam logic [3:0] PAT_LEFT_B  = 4'd14;
   localparam logic [3:0] PAT_RIGHT_A = 4'd4;
   localparam logic [3:0] PAT_RIGHT_B = 4'd11;

   typedef struct packed {
      logic north_level_n;
      logic south_level_n;
      logic east_level_n;
      logic west_level_n;
      logic centre_level_n;
      logic phase_a;
      logic phase_b;
      logic hold_repeat;
   } req_word_type;

   typedef struct packed {
      logic north_event;
      logic south_event;
      logic east_event;
      logic west_event;
      logic turn_left_event;
      logic turn_right_event;
      logic centre_event;
      logic long_press_event;
   } rsp_word_type;

   typedef struct packed {
      logic north;
      logic south;
      logic east;
      logic west;
      logic centre;
   } press_type;

endpackage

FILE: design/beeq_if.sv
// ----------------------------------------------------------------------------
// beeq_if
// Valid/ready channels for sample words and event words.
// ----------------------------------------------------------------------------
interface beeq_req_if;
   logic                   valid;
   logic                   ready;
   beeq_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface beeq_rsp_if;
   logic                   valid;
   logic                   ready;
   beeq_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

FILE: design/beeq_qualify.sv
// ----------------------------------------------------------------------------
// beeq_qualify
// Edge, turn and long-press qualification with its state and result register.
// ----------------------------------------------------------------------------
module beeq_qualify (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  beeq_pkg::req_word_type                 in_word,
   input  logic [beeq_pkg::THRESH_BITS-1:0]       threshold,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output beeq_pkg::rsp_word_type                 out_word
);

   logic                                   advance;
   beeq_pkg::press_type                    now_press;
   beeq_pkg::press_type                    last_press;
   beeq_pkg::press_type                    edge_press;
   logic [1:0]                             pair;
   logic [3:0]                             pattern;
   logic                                   left;
   logic                                   right;
   logic                                   centre_ev;
   logic                                   long_ev;
   logic [beeq_pkg::HOLD_COUNT_BITS-1:0]   hold_inc;

   logic                                   out_valid_ff, out_valid_in;
   beeq_pkg::rsp_word_type                 out_word_ff, out_word_in;
   logic [1:0]                             prev_pair_ff, prev_pair_in;
   beeq_pkg::press_type                    prev_press_ff, prev_press_in;
   logic [beeq_pkg::HOLD_COUNT_BITS-1:0]   hold_count_ff, hold_count_in;

   assign in_ready  = !out_valid_ff || out_ready;
   assign advance   = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   always_comb begin
      now_press.north  = !in_word.north_level_n;
      now_press.south  = !in_word.south_level_n;
      now_press.east   = !in_word.east_level_n;
      now_press.west   = !in_word.west_level_n;
      now_press.centre = !in_word.centre_level_n;

      last_press = prev_press_ff;
      if (in_word.hold_repeat) begin
         last_press.north = 1'b0;
         last_press.south = 1'b0;
         last_press.east  = 1'b0;
         last_press.west  = 1'b0;
      end
      edge_press = now_press & ~last_press;

      pair    = {in_word.phase_a, in_word.phase_b};
      pattern = {prev_pair_ff, pair};
      left    = 1'b0;
      right   = 1'b0;
      unique case (pattern) inside
         beeq_pkg::PAT_LEFT_A, beeq_pkg::PAT_LEFT_B:   left  = 1'b1;
         beeq_pkg::PAT_RIGHT_A, beeq_pkg::PAT_RIGHT_B: right = 1'b1;
         default: ;
      endcase

      hold_inc      = hold_count_ff + beeq_pkg::HOLD_COUNT_BITS'(1);
      hold_count_in = hold_count_ff;
      centre_ev     = 1'b0;
      long_ev       = 1'b0;
      if (now_press.centre) begin
         if (last_press.centre) begin
            hold_count_in = hold_inc;
            long_ev = (beeq_pkg::CMP_BITS'(hold_inc) ==
                       beeq_pkg::CMP_BITS'(threshold));
         end else begin
            centre_ev = 1'b1;
         end
      end else begin
         hold_count_in = '0;
      end

      out_word_in.north_event      = edge_press.north;
      out_word_in.south_event      = edge_press.south;
      out_word_in.east_event       = edge_press.east;
      out_word_in.west_event       = edge_press.west;
      out_word_in.turn_left_event  = left;
      out_word_in.turn_right_event = right;
      out_word_in.centre_event     = centre_ev;
      out_word_in.long_press_event = long_ev;

      prev_pair_in  = pair;
      prev_press_in = now_press;
      out_valid_in  = advance || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         prev_pair_ff  <= '0;
         prev_press_ff <= '0;
         hold_count_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            prev_pair_ff  <= prev_pair_in;
            prev_press_ff <= prev_press_in;
            hold_count_ff <= hold_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   // checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !out_valid_ff)
      else $error("result valid after reset");

   a_turn_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_word_ff.turn_left_event && out_word_ff.turn_right_event))
      else $error("left and right turn together");

   a_centre_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_word_ff.centre_event && out_word_ff.long_press_event))
      else $error("centre press and long press together");

   a_centre_state: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.centre_event) |->
         (prev_press_ff.centre && hold_count_ff == '0))
      else $error("centre press without fresh hold state");

   a_hold_release: assert property (@(posedge clock) disable iff (reset)
      !prev_press_ff.centre |-> hold_count_ff == '0)
      else $error("hold count nonzero with centre released");

endmodule

FILE: design/button_encoder_event_qualifier.sv
// ----------------------------------------------------------------------------
// button_encoder_event_qualifier
// Turns raw button and encoder samples into press, turn and long-press events.
// ----------------------------------------------------------------------------
// req_if carries one sample word per tick: four active-low direction buttons,
// the active-low centre button, encoder phases a and b and the hold-repeat
// flag. rsp_if returns one event word for every sample word, in order.
// csr_we/csr_wdata write the long-press threshold (reset 50 ticks); write it
// only while no sample word is in flight.
// A word accepted from req_if lands in the input register, is qualified
// against the stored button, phase and hold state as it moves into the
// result register, and shows on rsp_if from there. One word per cycle is
// sustained while rsp_if takes result words; the input register and result
// register each hold one word, so a stalled receiver fills both before
// req_if.ready drops, and the result word holds steady until taken.
// Reset empties both registers, clears the previous phase pair, the
// previous button levels and the centre hold counter, and restores the
// threshold.
// ----------------------------------------------------------------------------
module button_encoder_event_qualifier (
   input  logic                                  clock,
   input  logic                                  reset,
   beeq_req_if.sink                              req_if,
   beeq_rsp_if.source                            rsp_if,
   input  logic                                  csr_we,
   input  logic [beeq_pkg::THRESH_BITS-1:0]      csr_wdata
);

   logic                                   stage_ready;
   logic                                   req_take;
   logic                                   stage_valid_ff, stage_valid_in;
   beeq_pkg::req_word_type                 stage_word_ff;
   logic [beeq_pkg::THRESH_BITS-1:0]       threshold_ff, threshold_in;

   assign req_if.ready   = !stage_valid_ff || stage_ready;
   assign req_take       = req_if.valid && req_if.ready;
   assign stage_valid_in = req_take || (stage_valid_ff && !stage_ready);
   assign threshold_in   = csr_we ? csr_wdata : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         threshold_ff   <= beeq_pkg::LONG_PRESS_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         threshold_ff   <= threshold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_word_ff <= req_if.word;
      end
   end

   beeq_qualify u_qualify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid_ff),
      .in_ready  (stage_ready),
      .in_word   (stage_word_ff),
      .threshold (threshold_ff),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_word  (rsp_if.word)
   );

endmodule

FILE: tb/button_encoder_event_qualifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_encoder_event_qualifier_tb
// Drives sample words into the event qualifier through a queue-fed driver.
// A clocked monitor checks each event word against a local model of the
// button edge, encoder turn and centre long-press logic. Both sides idle at
// random. The long-press threshold is rewritten between phases, with zero
// and the largest value among the settings.
// ----------------------------------------------------------------------------
module button_encoder_event_qualifier_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 200;

   typedef struct {
      beeq_pkg::req_word_type word;
      int unsigned            gap;
   } queued_sample_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [beeq_pkg::THRESH_BITS-1:0] csr_wdata;

   beeq_req_if req_if ();
   beeq_rsp_if rsp_if ();

   button_encoder_event_qualifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   queued_sample_type      sample_queue[$];
   beeq_pkg::rsp_word_type expected_events[$];
   int unsigned            mismatch_count;
   int unsigned            phase_items;

   // model state
   logic [1:0]                           last_phase_pair;
   beeq_pkg::press_type                  last_pressed;
   logic [beeq_pkg::HOLD_COUNT_BITS-1:0] centre_hold_count;
   logic [beeq_pkg::THRESH_BITS-1:0]     long_press_thresh;

   logic [1:0] enc_pair;
   logic [1:0] cw_next  [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
   logic [1:0] ccw_next [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   string field_names [8] = '{"north_event", "south_event", "east_event", "west_event",
                              "turn_left_event", "turn_right_event", "centre_event",
                              "long_press_event"};

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.word = '0;
      rsp_if.ready = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic beeq_pkg::rsp_word_type qualify_sample(beeq_pkg::req_word_type s);
      beeq_pkg::press_type    now;
      beeq_pkg::press_type    prior;
      beeq_pkg::press_type    rise;
      logic [1:0]             pair;
      logic [3:0]             pattern;
      beeq_pkg::rsp_word_type ev;
      pair = {s.phase_a, s.phase_b};
      pattern = {last_phase_pair, pair};
      now.north = ~s.north_level_n;
      now.south = ~s.south_level_n;
      now.east = ~s.east_level_n;
      now.west = ~s.west_level_n;
      now.centre = ~s.centre_level_n;
      prior = last_pressed;
      if (s.hold_repeat) begin
         prior.north = 1'b0;
         prior.south = 1'b0;
         prior.east = 1'b0;
         prior.west = 1'b0;
      end
      rise = beeq_pkg::press_type'(now & ~prior);
      ev = '0;
      ev.north_event = rise.north;
      ev.south_event = rise.south;
      ev.east_event = rise.east;
      ev.west_event = rise.west;
      ev.turn_left_event = (pattern == beeq_pkg::PAT_LEFT_A) ||
                           (pattern == beeq_pkg::PAT_LEFT_B);
      ev.turn_right_event = (pattern == beeq_pkg::PAT_RIGHT_A) ||
                            (pattern == beeq_pkg::PAT_RIGHT_B);
      if (now.centre) begin
         if (prior.centre) begin
            centre_hold_count = centre_hold_count + beeq_pkg::HOLD_COUNT_BITS'(1);
            if (beeq_pkg::CMP_BITS'(centre_hold_count) ==
                beeq_pkg::CMP_BITS'(long_press_thresh))
               ev.long_press_event = 1'b1;
         end else begin
            ev.centre_event = 1'b1;
         end
      end else begin
         centre_hold_count = '0;
      end
      last_pressed = now;
      last_phase_pair = pair;
      return ev;
   endfunction

   task automatic push_word(beeq_pkg::req_word_type w, int unsigned gap);
      queued_sample_type q;
      q.word = w;
      q.gap = gap;
      sample_queue.push_back(q);
      phase_items++;
   endtask

   // dir: 0 random phases, 1 clockwise, 2 counter-clockwise
   task automatic push_sample(logic centre_dn, logic quiet, int dir);
      beeq_pkg::req_word_type w;
      w.north_level_n = ($urandom_range(0, 2) != 0);
      w.south_level_n = ($urandom_range(0, 2) != 0);
      w.east_level_n = ($urandom_range(0, 2) != 0);
      w.west_level_n = ($urandom_range(0, 2) != 0);
      w.centre_level_n = ~centre_dn;
      w.hold_repeat = ($urandom_range(0, 3) == 0);
      if (dir != 0 && $urandom_range(0, 5) != 0)
         enc_pair = (dir == 1) ? cw_next[enc_pair] : ccw_next[enc_pair];
      else
         enc_pair = 2'($urandom_range(0, 3));
      w.phase_a = enc_pair[1];
      w.phase_b = enc_pair[0];
      push_word(w, quiet ? 0 : pick_gap());
   endtask

   task automatic push_burst();
      int unsigned kind;
      int          len;
      int          dir;
      logic        quiet;
      kind = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      dir = $urandom_range(1, 2);
      if (kind <= 3) begin
         // centre held around the threshold, sometimes long enough to wrap
         len = int'(long_press_thresh) + 1 + $urandom_range(0, 4) - 2;
         if (len < 1) len = 1;
         if ($urandom_range(0, 4) == 0) len += 256;
         repeat (len) push_sample(1'b1, quiet, dir);
         push_sample(1'b0, quiet, dir);
      end else if (kind <= 6) begin
         len = $urandom_range(4, 24);
         repeat (len) push_sample(1'($urandom_range(0, 1)), quiet, dir);
      end else if (kind <= 8) begin
         len = $urandom_range(4, 16);
         repeat (len) push_sample(1'($urandom_range(0, 1)), quiet, 0);
      end else begin
         // broken hold
         len = $urandom_range(1, 5);
         repeat (len) push_sample(1'b1, quiet, 0);
         push_sample(1'b0, quiet, 0);
      end
   endtask

   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_if.valid || expected_events.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_long_press(logic [beeq_pkg::THRESH_BITS-1:0] v);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      long_press_thresh = v;
   endtask

   task automatic push_directed();
      beeq_pkg::req_word_type w;
      logic [1:0]   pairs [16] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3,
                                  2'd1, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3};
      logic [1:0]   tail [3] = '{2'd3, 2'd0, 2'd0};
      for (int i = 0; i < 19; i++) begin
         logic [4:0] k;
         k = 5'(i);
         if (i == 0) w = '1;
         else if (i == 1) w = '0;
         else if (i == 2) begin
            w = '0;
            w.hold_repeat = 1'b1;
         end else begin
            w.north_level_n = k[0];
            w.south_level_n = k[1];
            w.east_level_n = k[2];
            w.west_level_n = k[3];
            w.centre_level_n = k[0] ^ k[1];
            w.hold_repeat = k[2] ^ k[0];
         end
         enc_pair = (i < 16) ? pairs[i] : tail[i - 16];
         w.phase_a = enc_pair[1];
         w.phase_b = enc_pair[0];
         push_word(w, (i % 3 == 0) ? 0 : pick_gap());
      end
   endtask

   // driver
   int unsigned gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.word <= '0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_events.push_back(qualify_sample(req_if.word));
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               queued_sample_type q;
               q = sample_queue.pop_front();
               req_if.word <= q.word;
               req_if.valid <= 1'b1;
               gap_left = q.gap;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls
   int unsigned hold_left;
   int unsigned rsp_cycle;
   logic        rsp_quiet;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
         rsp_cycle = 0;
         rsp_quiet = 1'b0;
      end else begin
         int unsigned g;
         rsp_cycle++;
         if (rsp_cycle % 400 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         if (rsp_cycle == 1500 || rsp_cycle == 9000) begin
            // long hold-off so the block backs up into req_if
            hold_left = 300;
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_quiet) begin
            rsp_if.ready <= 1'b1;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               hold_left = g - 1;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // monitor
   beeq_pkg::rsp_word_type want;
   beeq_pkg::rsp_word_type got;
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.word;
         if (expected_events.size() == 0) begin
            $error("event word %b with nothing expected", got);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            for (int i = 0; i < 8; i++)
               if (got[7-i] !== want[7-i]) begin
                  $error("%s expected %0b actual %0b", field_names[i], want[7-i], got[7-i]);
                  mismatch_count++;
               end
         end
      end
   end

   // watchdog
   int unsigned stuck_cycles;
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      logic [beeq_pkg::THRESH_BITS-1:0] settings [6];
      mismatch_count = 0;
      phase_items = 0;
      last_phase_pair = '0;
      last_pressed = '0;
      centre_hold_count = '0;
      long_press_thresh = beeq_pkg::LONG_PRESS_RESET;
      enc_pair = '0;
      settings = '{beeq_pkg::LONG_PRESS_RESET, 8'd0, 8'd1, 8'd255, 8'd7,
                   8'($urandom_range(0, 255))};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         if (p != 0) set_long_press(settings[p]);
         phase_items = 0;
         if (p == 0) push_directed();
         while (phase_items < PHASE_ITEMS) begin
            push_burst();
            while (sample_queue.size() > 64) @(negedge clock);
         end
      end
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
design/beeq_pkg.sv
design/beeq_if.sv
design/beeq_qualify.sv
design/button_encoder_event_qualifier.sv
tb/button_encoder_event_qualifier_tb.sv
